/* rtl/assert_macros.svh */
// Assertion macros shared by the priority queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SSPQ_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Check that a cause is followed by an effect in the next cycle.
`define SSPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sspq_pkg.sv */
// Types and constants shared by the sorted priority queue cells and top level.
package sspq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PrioW  = 16;
  localparam int unsigned OccW   = 5;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef enum logic [1:0] {
    STATUS_ENQUEUED  = 2'd0,
    STATUS_DEQUEUED  = 2'd1,
    STATUS_UNDERFLOW = 2'd2,
    STATUS_OVERFLOW  = 2'd3
  } status_e;

  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [ValueW-1:0] value;
    logic signed [PrioW-1:0]  prio;
  } op_t;

endpackage

/* rtl/sspq_cell.sv */
// One slot of the sorted chain: holds, takes the new entry, or shifts from a neighbor.
module sspq_cell (
  input  logic                              clk_i,
  input  sspq_pkg::op_t                     op_i,
  input  logic                              in_use_i,
  input  logic                              left_keep_i,
  input  logic signed [sspq_pkg::ValueW-1:0] left_value_i,
  input  logic signed [sspq_pkg::PrioW-1:0]  left_prio_i,
  input  logic signed [sspq_pkg::ValueW-1:0] right_value_i,
  input  logic signed [sspq_pkg::PrioW-1:0]  right_prio_i,
  output logic signed [sspq_pkg::ValueW-1:0] value_o,
  output logic signed [sspq_pkg::PrioW-1:0]  prio_o,
  output logic                              keep_o
);

  logic signed [sspq_pkg::ValueW-1:0] value_q;
  logic signed [sspq_pkg::PrioW-1:0]  prio_q;

  assign keep_o  = in_use_i && (prio_q >= op_i.prio);
  assign value_o = value_q;
  assign prio_o  = prio_q;

  always_ff @(posedge clk_i) begin
    if (op_i.ins) begin
      if (!keep_o) begin
        if (left_keep_i) begin
          value_q <= op_i.value;
          prio_q  <= op_i.prio;
        end else begin
          value_q <= left_value_i;
          prio_q  <= left_prio_i;
        end
      end
    end else if (op_i.rem) begin
      value_q <= right_value_i;
      prio_q  <= right_prio_i;
    end
  end

endmodule

/* rtl/stable_sorted_priority_queue_core.sv */
// Top level of the stable sorted priority queue built as a chain of cells.
//
//  channel | direction | beat fields
//  --------+-----------+-------------------------------------------------
//  in      | to core   | cmd_i, item_value_i, item_priority_i
//  out     | from core | status_o, out_value_o, out_priority_o, occupancy_o
//
// One beat per cycle unless out stalls: every cell compares against the new
// priority at once and shifts one slot in the same cycle; the result is registered.
// A new input beat is taken while the result register is empty or being read.
// Reset clears the count and result valid; slot contents stay unknown.
// Stalls on the out side hold the result and block further input beats.
`include "assert_macros.svh"

module stable_sorted_priority_queue_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               cmd_i,
  input  logic signed [sspq_pkg::ValueW-1:0] item_value_i,
  input  logic signed [sspq_pkg::PrioW-1:0]  item_priority_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         status_o,
  output logic signed [sspq_pkg::ValueW-1:0] out_value_o,
  output logic signed [sspq_pkg::PrioW-1:0]  out_priority_o,
  output logic [sspq_pkg::OccW-1:0]          occupancy_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  logic [1:0]      status_q, status_d;
  logic signed [sspq_pkg::ValueW-1:0] out_value_q, out_value_d;
  logic signed [sspq_pkg::PrioW-1:0]  out_prio_q, out_prio_d;
  logic [sspq_pkg::OccW-1:0]          occ_q;

  logic          accept;
  logic          full;
  logic          empty;
  sspq_pkg::op_t op;

  logic signed [sspq_pkg::ValueW-1:0] cell_value [CAPACITY];
  logic signed [sspq_pkg::PrioW-1:0]  cell_prio  [CAPACITY];
  logic [CAPACITY-1:0]                cell_keep;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(CAPACITY));
  assign empty      = (count_q == '0);

  assign op.ins   = accept && (cmd_i == sspq_pkg::CMD_ENQ) && !full;
  assign op.rem   = accept && (cmd_i == sspq_pkg::CMD_DEQ) && !empty;
  assign op.value = item_value_i;
  assign op.prio  = item_priority_i;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                               left_keep;
    logic signed [sspq_pkg::ValueW-1:0] left_value;
    logic signed [sspq_pkg::PrioW-1:0]  left_prio;
    logic signed [sspq_pkg::ValueW-1:0] right_value;
    logic signed [sspq_pkg::PrioW-1:0]  right_prio;

    if (i == 0) begin : g_head
      assign left_keep  = 1'b1;
      assign left_value = '0;
      assign left_prio  = '0;
    end else begin : g_body
      assign left_keep  = cell_keep[i-1];
      assign left_value = cell_value[i-1];
      assign left_prio  = cell_prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = '0;
      assign right_prio  = '0;
    end else begin : g_next
      assign right_value = cell_value[i+1];
      assign right_prio  = cell_prio[i+1];
    end

    sspq_cell u_cell (
      .clk_i         (clk_i),
      .op_i          (op),
      .in_use_i      (CntW'(i) < count_q),
      .left_keep_i   (left_keep),
      .left_value_i  (left_value),
      .left_prio_i   (left_prio),
      .right_value_i (right_value),
      .right_prio_i  (right_prio),
      .value_o       (cell_value[i]),
      .prio_o        (cell_prio[i]),
      .keep_o        (cell_keep[i])
    );
  end

  always_comb begin
    count_d     = count_q;
    out_value_d = '0;
    out_prio_d  = '0;
    if (cmd_i == sspq_pkg::CMD_DEQ) begin
      if (empty) begin
        status_d = sspq_pkg::STATUS_UNDERFLOW;
      end else begin
        status_d    = sspq_pkg::STATUS_DEQUEUED;
        out_value_d = cell_value[0];
        out_prio_d  = cell_prio[0];
        count_d     = count_q - CntW'(1);
      end
    end else begin
      if (full) begin
        status_d = sspq_pkg::STATUS_OVERFLOW;
      end else begin
        status_d = sspq_pkg::STATUS_ENQUEUED;
        count_d  = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      out_value_q <= out_value_d;
      out_prio_q  <= out_prio_d;
      occ_q       <= sspq_pkg::OccW'(count_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_value_o    = out_value_q;
  assign out_priority_o = out_prio_q;
  assign occupancy_o    = occ_q;

  `SSPQ_ASSERT(a_count_bound, count_q <= CntW'(CAPACITY), "entry count above capacity")
  `SSPQ_ASSERT(a_head_sorted,
      (count_q < CntW'(2)) || (cell_prio[0] >= cell_prio[1]), "head slots out of order")
  `SSPQ_ASSERT_NEXT(a_insert_count, op.ins, count_q == $past(count_q) + CntW'(1),
      "insert did not advance count")
  `SSPQ_ASSERT_NEXT(a_remove_count, op.rem, count_q == $past(count_q) - CntW'(1),
      "remove did not drop count")

endmodule

/* sim/stable_sorted_priority_queue_core_tb.sv */
// Testbench for stable_sorted_priority_queue_core: random traffic checked against a shadow queue.
`timescale 1ns / 100ps

module stable_sorted_priority_queue_core_tb;

  localparam int unsigned Depth       = 16;
  localparam int unsigned QuietLimit  = 1000;
  localparam int unsigned PhaseCount  = 18;
  localparam int unsigned PhaseBeats  = 60;
  localparam int unsigned ValueW      = sspq_pkg::ValueW;
  localparam int unsigned PrioW       = sspq_pkg::PrioW;
  localparam int unsigned OccW        = sspq_pkg::OccW;

  typedef struct {
    sspq_pkg::status_e        status;
    logic signed [ValueW-1:0] value;
    logic signed [PrioW-1:0]  prio;
    logic [OccW-1:0]          occ;
  } queue_result_t;

  class queue_shadow;
    logic signed [ValueW-1:0] slot_value [Depth];
    logic signed [PrioW-1:0]  slot_prio [Depth];
    int unsigned              held = 0;
    queue_result_t            pending_results[$];
    int unsigned              errors = 0;
    int unsigned              status_seen[4] = '{0, 0, 0, 0};

    function void note_request(logic cmd, logic signed [ValueW-1:0] value,
                               logic signed [PrioW-1:0] prio);
      queue_result_t r;
      int unsigned   pos;
      int unsigned   i;
      r.value = '0;
      r.prio  = '0;
      if (cmd == sspq_pkg::CMD_DEQ) begin
        if (held == 0) begin
          r.status = sspq_pkg::STATUS_UNDERFLOW;
        end else begin
          r.status = sspq_pkg::STATUS_DEQUEUED;
          r.value  = slot_value[0];
          r.prio   = slot_prio[0];
          for (i = 1; i < held; i++) begin
            slot_value[i-1] = slot_value[i];
            slot_prio[i-1]  = slot_prio[i];
          end
          held--;
        end
      end else if (held >= Depth) begin
        r.status = sspq_pkg::STATUS_OVERFLOW;
      end else begin
        pos = 0;
        while (pos < held && slot_prio[pos] >= prio) pos++;
        for (i = held; i > pos; i--) begin
          slot_value[i] = slot_value[i-1];
          slot_prio[i]  = slot_prio[i-1];
        end
        slot_value[pos] = value;
        slot_prio[pos]  = prio;
        held++;
        r.status = sspq_pkg::STATUS_ENQUEUED;
      end
      r.occ = held[OccW-1:0];
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic signed [ValueW-1:0] value,
                               logic signed [PrioW-1:0] prio, logic [OccW-1:0] occ);
      queue_result_t r;
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: status %0d", status);
        errors++;
        return;
      end
      r = pending_results.pop_front();
      status_seen[r.status]++;
      if (status !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, status);
        errors++;
      end
      if (value !== r.value) begin
        $error("out_value: expected %0d, got %0d", r.value, value);
        errors++;
      end
      if (prio !== r.prio) begin
        $error("out_priority: expected %0d, got %0d", r.prio, prio);
        errors++;
      end
      if (occ !== r.occ) begin
        $error("occupancy: expected %0d, got %0d", r.occ, occ);
        errors++;
      end
    endfunction
  endclass

  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b0;
  logic                     in_valid_i      = 1'b0;
  logic                     in_ready_o;
  logic                     cmd_i           = sspq_pkg::CMD_ENQ;
  logic signed [ValueW-1:0] item_value_i    = '0;
  logic signed [PrioW-1:0]  item_priority_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i     = 1'b0;
  logic [1:0]               status_o;
  logic signed [ValueW-1:0] out_value_o;
  logic signed [PrioW-1:0]  out_priority_o;
  logic [OccW-1:0]          occupancy_o;

  queue_shadow shadow = new;
  bit          steady = 1'b0;
  int unsigned quiet  = 0;
  int unsigned beats  = 0;

  stable_sorted_priority_queue_core #(
    .CAPACITY(Depth)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .item_value_i   (item_value_i),
    .item_priority_i(item_priority_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .out_value_o    (out_value_o),
    .out_priority_o (out_priority_o),
    .occupancy_o    (occupancy_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_beat(logic cmd, logic signed [ValueW-1:0] value,
                           logic signed [PrioW-1:0] prio);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= cmd;
    item_value_i    <= value;
    item_priority_i <= prio;
    do @(negedge clk_i); while (!in_ready_o);
    shadow.note_request(cmd, value, prio);
    beats++;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (shadow.pending_results.size() != 0);
    @(posedge clk_i);
  endtask

  function automatic logic signed [PrioW-1:0] pick_prio(int unsigned mode);
    case (mode)
      0:       return PrioW'($urandom_range(0, 65535));
      1:       return PrioW'(int'($urandom_range(0, 3)) - 2);
      default: begin
        case ($urandom_range(0, 4))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return -16'sd1;
          3:       return 16'sd0;
          default: return 16'sd1;
        endcase
      end
    endcase
  endfunction

  // result side: random back-pressure
  initial begin
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(negedge clk_i); while (!out_valid_o);
      @(posedge clk_i);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      shadow.check_result(status_o, out_value_o, out_priority_o, occupancy_o);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QuietLimit) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned enq_pct;
    int unsigned prio_mode;
    logic        cmd;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // dequeue on empty, fill with extreme and tied priorities, overflow, partial drain
    send_beat(sspq_pkg::CMD_DEQ, '1, '1);
    send_beat(sspq_pkg::CMD_ENQ, 32'sh7fffffff, 16'sd0);
    send_beat(sspq_pkg::CMD_ENQ, 32'sh80000000, 16'sh7fff);
    send_beat(sspq_pkg::CMD_ENQ, 32'sd0, 16'sh8000);
    send_beat(sspq_pkg::CMD_ENQ, -32'sd1, 16'sd0);
    send_beat(sspq_pkg::CMD_ENQ, 32'sd1, 16'sh7fff);
    send_beat(sspq_pkg::CMD_ENQ, 32'sd2, 16'sh8000);
    send_beat(sspq_pkg::CMD_ENQ, 32'sd3, -16'sd1);
    send_beat(sspq_pkg::CMD_ENQ, 32'sd4, 16'sd1);
    for (int k = 5; k < 13; k++) begin
      send_beat(sspq_pkg::CMD_ENQ, k, (k % 2 == 0) ? 16'sd0 : 16'sh7fff);
    end
    send_beat(sspq_pkg::CMD_ENQ, 32'sh5a5a5a5a, 16'sh7fff);
    send_beat(sspq_pkg::CMD_ENQ, 32'sh12345678, 16'sd0);
    repeat (6) send_beat(sspq_pkg::CMD_DEQ, $urandom, PrioW'($urandom_range(0, 65535)));
    drain_results();

    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase % 6)
        0:       enq_pct = 95;
        1:       enq_pct = 50;
        2:       enq_pct = 15;
        3:       enq_pct = 80;
        4:       enq_pct = 40;
        default: enq_pct = 60;
      endcase
      prio_mode = phase % 3;
      steady    = (phase % 5 == 2);
      for (int n = 0; n < PhaseBeats; n++) begin
        cmd = ($urandom_range(0, 99) < enq_pct) ? sspq_pkg::CMD_ENQ : sspq_pkg::CMD_DEQ;
        send_beat(cmd, $urandom, pick_prio(prio_mode));
      end
      if (phase % 4 == 3) drain_results();
    end
    steady = 1'b0;

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("Run covered %0d beats: %0d enqueued, %0d dequeued, %0d underflow, %0d overflow",
             beats, shadow.status_seen[sspq_pkg::STATUS_ENQUEUED],
             shadow.status_seen[sspq_pkg::STATUS_DEQUEUED],
             shadow.status_seen[sspq_pkg::STATUS_UNDERFLOW],
             shadow.status_seen[sspq_pkg::STATUS_OVERFLOW]);
    if (shadow.errors == 0 && shadow.pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
